### rtl/etsc_pkg.sv
// Package for the e-bike throttle safety controller.
// Holds the field widths, register indexes, status codes, sequencer types and
// divider constants. It has no dependencies of its own.
package etsc_pkg;

  // Field widths.
  localparam int ADC_W    = 10;
  localparam int PWM_W    = 8;
  localparam int RPM_FRAC = 8;
  localparam int RPM_W    = 16 + RPM_FRAC;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Input and result packing widths.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  // Shared divider sizes: the dividend is shifted out of the quotient register.
  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_REM_W = DIV_DEN_W + 1;
  localparam int CNT_W     = 6;
  localparam int SHORT_W   = 28;
  localparam int SHORT_PAD = DIV_NUM_W - SHORT_W;

  localparam logic [CNT_W-1:0] DIV_LEN_LONG  = CNT_W'(DIV_NUM_W);
  localparam logic [CNT_W-1:0] DIV_LEN_SHORT = CNT_W'(SHORT_W);

  // 60e6 scaled to the fractional RPM format.
  localparam logic [63:0] SPEED_NUM_FULL = 64'd60000000 << RPM_FRAC;
  localparam logic [DIV_NUM_W-1:0] SPEED_NUM = SPEED_NUM_FULL[DIV_NUM_W-1:0];
  localparam logic [RPM_W-1:0] RPM_SAT = '1;

  // Reciprocal of ten, ceil(2^32 / 10); exact for filter sums below 2^30.
  localparam int RECIP_W  = 29;
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_W-1:0] RECIP_10 = 29'h1999999A;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_CUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_REC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_PER   = 3'd6;

  // Drive status codes.
  localparam logic [1:0] ST_DRIVE = 2'd0;
  localparam logic [1:0] ST_BATT  = 2'd1;
  localparam logic [1:0] ST_BRAKE = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  // Input item kinds.
  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_DEN  = 9'b0_0000_0010,
    S_DIV  = 9'b0_0000_0100,
    S_MIX  = 9'b0_0000_1000,
    S_RCP  = 9'b0_0001_0000,
    S_STAT = 9'b0_0010_0000,
    S_SQ   = 9'b0_0100_0000,
    S_SP   = 9'b0_1000_0000,
    S_DONE = 9'b1_0000_0000
  } state_t;

  // What the divider is working on.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CURVE  = 2'd1
  } op_t;

endpackage

### rtl/ebike_throttle_safety_controller_top.sv
// Top level of the e-bike throttle safety controller.
// Depends on etsc_pkg for widths, codes and sequencer types.
//
// A hall-pulse item (tuser mode 0) is taken in S_IDLE and gives no result. A
// control tick keeps in_tready low after its accepting cycle. When a cut
// decides the result it passes S_STAT and S_DONE; a throttle result goes on
// through S_SQ, S_SP and a curve division in S_DIV. When the speed period has
// run out and the pulse interval is nonzero, a speed update through S_DEN,
// S_DIV, S_MIX and S_RCP comes first. A single restoring divider retires one
// quotient bit per cycle and is shared by the RPM sample (34 steps) and the
// throttle curve (28 steps), next to one shared 32x10 multiplier. The 0.7/0.3
// filter registers its weighted sum in S_MIX and divides it by ten with a
// constant reciprocal multiply in the next state, S_RCP. A finished result
// waits in the output register while the next item is accepted; a later tick
// holds in S_DONE for as long as an earlier result still waits there.
module ebike_throttle_safety_controller_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [etsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [etsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0: time_us[31:0], time_ms[63:32], throttle_adc[73:64],
  // brake[74], battery_adc[84:75], zero fill[87:85].
  input  logic [etsc_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: mode[0].
  input  logic                                 in_tuser,
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata from bit 0: pwm_duty[7:0], speed_rpm[23:8].
  output logic [etsc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: drive_status[1:0].
  output logic [1:0]                           out_tuser
);
  import etsc_pkg::*;

  // Configuration registers.
  logic [ADC_W-1:0] tmin_r, tmin_nxt, tmax_r, tmax_nxt;
  logic [15:0]      maxrpm_r, maxrpm_nxt, period_r, period_nxt;
  logic [7:0]       ppr_r, ppr_nxt;
  logic [ADC_W-1:0] bcut_r, bcut_nxt, brec_r, brec_nxt;

  // Block state.
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [31:0]      last_pulse_r, last_pulse_nxt, interval_r, interval_nxt;
  logic [31:0]      last_speed_r, last_speed_nxt;
  logic [RPM_W-1:0] filt_r, filt_nxt, cur_r, cur_nxt;
  logic             cut_r, cut_nxt;

  // Latched tick fields.
  logic [ADC_W-1:0] thr_r, thr_nxt;
  logic             brake_r, brake_nxt;

  // Divider registers.
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [19:0]          d2_r, d2_nxt;

  // Result being built and the output register.
  logic [PWM_W-1:0] pwm_r, pwm_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PWM_W-1:0] out_pwm_r, out_pwm_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [15:0]      out_rpm_r, out_rpm_nxt;

  // Input field views.
  logic             in_acc;
  logic             in_mode;
  logic [31:0]      in_time_us, in_time_ms, elapsed;
  logic [ADC_W-1:0] in_thr, in_batt;
  logic             in_brake, speed_due, cut_set;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [9:0]  mul_b;
  logic [41:0] mul_p;

  // Divider step and other datapath values.
  logic [DIV_REM_W-1:0] rem_sh;
  logic [DIV_REM_W:0]   div_diff;
  logic                 div_ge;
  logic [DIV_REM_W-1:0] rem_step;
  logic [DIV_NUM_W-1:0] quo_step;
  logic [7:0]           ppr_eff;
  logic [ADC_W-1:0]     thr_clip, d_val, span;
  logic                 curve_ok;
  logic [RPM_W-1:0]     sample_sat;
  logic [SHORT_W-1:0]   mix_sum, curve_num;
  logic [SHORT_W+RECIP_W-1:0] mix_prod;
  logic [RPM_W-1:0]     mix_q;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rpm_r, out_pwm_r};
  assign out_tuser  = out_status_r;

  assign in_acc     = in_tvalid && in_tready;
  assign in_mode    = in_tuser;
  assign in_time_us = in_tdata[31:0];
  assign in_time_ms = in_tdata[63:32];
  assign in_thr     = in_tdata[73:64];
  assign in_brake   = in_tdata[74];
  assign in_batt    = in_tdata[84:75];

  // Speed period check and battery hysteresis for a tick.
  assign elapsed   = in_time_ms - last_speed_r;
  assign speed_due = elapsed > {16'd0, period_r};
  assign cut_set   = cut_r || (in_batt < bcut_r);

  // Throttle curve operands.
  assign ppr_eff  = (ppr_r == 8'd0) ? 8'd1 : ppr_r;
  assign thr_clip = (thr_r > tmax_r) ? tmax_r : thr_r;
  assign d_val    = thr_clip - tmin_r;
  assign span     = tmax_r - tmin_r;
  assign curve_ok = (tmax_r > tmin_r) && (thr_r >= tmin_r);

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      S_DEN: begin
        mul_a = interval_r;
        mul_b = {2'd0, ppr_eff};
      end
      S_SQ: begin
        mul_a = {22'd0, d_val};
        mul_b = d_val;
      end
      S_SP: begin
        mul_a = {22'd0, span};
        mul_b = span;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring division step.
  assign rem_sh   = {rem_r[DIV_REM_W-2:0], quo_r[DIV_NUM_W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b0, den_r};
  assign div_ge   = !div_diff[DIV_REM_W];
  assign rem_step = div_ge ? div_diff[DIV_REM_W-1:0] : rem_sh;
  assign quo_step = {quo_r[DIV_NUM_W-2:0], div_ge};

  // Filter sum 7*old + 3*sample and curve numerator d^2 * 255.
  assign sample_sat = (|quo_r[DIV_NUM_W-1:RPM_W]) ? RPM_SAT : quo_r[RPM_W-1:0];
  assign mix_sum    = ({4'd0, filt_r} << 3) - {4'd0, filt_r}
                    + ({4'd0, sample_sat} << 1) + {4'd0, sample_sat};
  assign curve_num  = {d2_r, 8'd0} - {8'd0, d2_r};

  // The registered filter sum divided by ten through its reciprocal.
  assign mix_prod = quo_r[SHORT_W-1:0] * RECIP_10;
  assign mix_q    = mix_prod[RECIP_SH+RPM_W-1:RECIP_SH];

  // Sequencer and next values.
  always_comb begin
    tmin_nxt       = tmin_r;
    tmax_nxt       = tmax_r;
    maxrpm_nxt     = maxrpm_r;
    ppr_nxt        = ppr_r;
    bcut_nxt       = bcut_r;
    brec_nxt       = brec_r;
    period_nxt     = period_r;
    state_nxt      = state_r;
    op_nxt         = op_r;
    last_pulse_nxt = last_pulse_r;
    interval_nxt   = interval_r;
    last_speed_nxt = last_speed_r;
    filt_nxt       = filt_r;
    cur_nxt        = cur_r;
    cut_nxt        = cut_r;
    thr_nxt        = thr_r;
    brake_nxt      = brake_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    den_nxt        = den_r;
    cnt_nxt        = cnt_r;
    d2_nxt         = d2_r;
    pwm_nxt        = pwm_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_pwm_nxt    = out_pwm_r;
    out_status_nxt = out_status_r;
    out_rpm_nxt    = out_rpm_r;

    // A taken result frees the output register.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THR_MIN:  tmin_nxt   = cfg_data[ADC_W-1:0];
        CFG_THR_MAX:  tmax_nxt   = cfg_data[ADC_W-1:0];
        CFG_MAX_RPM:  maxrpm_nxt = cfg_data;
        CFG_PPR:      ppr_nxt    = cfg_data[7:0];
        CFG_BATT_CUT: bcut_nxt   = cfg_data[ADC_W-1:0];
        CFG_BATT_REC: brec_nxt   = cfg_data[ADC_W-1:0];
        CFG_SPD_PER:  period_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_PULSE) begin
            interval_nxt   = in_time_us - last_pulse_r;
            last_pulse_nxt = in_time_us;
          end else begin
            thr_nxt   = in_thr;
            brake_nxt = in_brake;
            cut_nxt   = cut_set && !(in_batt >= brec_r);
            state_nxt = S_STAT;
            if (speed_due) begin
              last_speed_nxt = in_time_ms;
              if (interval_r == 32'd0) begin
                cur_nxt = '0;
              end else begin
                state_nxt = S_DEN;
              end
            end
          end
        end
      end
      S_DEN: begin
        // Divisor is interval times pulses per revolution.
        den_nxt   = mul_p[DIV_DEN_W-1:0];
        rem_nxt   = '0;
        quo_nxt   = SPEED_NUM;
        cnt_nxt   = DIV_LEN_LONG;
        op_nxt    = OP_SAMPLE;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          unique case (op_r)
            OP_SAMPLE: state_nxt = S_MIX;
            OP_CURVE: begin
              pwm_nxt   = quo_step[PWM_W-1:0];
              state_nxt = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MIX: begin
        // Hold the weighted sum for the divide by ten.
        quo_nxt   = {SHORT_PAD'(0), mix_sum};
        state_nxt = S_RCP;
      end
      S_RCP: begin
        filt_nxt  = mix_q;
        cur_nxt   = mix_q;
        state_nxt = S_STAT;
      end
      S_STAT: begin
        pwm_nxt   = '0;
        state_nxt = S_DONE;
        if (cut_r) begin
          status_nxt = ST_BATT;
        end else if (brake_r) begin
          status_nxt = ST_BRAKE;
        end else if (cur_r > {maxrpm_r, RPM_FRAC'(0)}) begin
          status_nxt = ST_OVER;
        end else begin
          status_nxt = ST_DRIVE;
          if (curve_ok) begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        d2_nxt    = mul_p[19:0];
        state_nxt = S_SP;
      end
      S_SP: begin
        // Divisor is span squared, dividend is d squared times full scale.
        den_nxt   = DIV_DEN_W'(mul_p[19:0]);
        rem_nxt   = '0;
        quo_nxt   = {curve_num, SHORT_PAD'(0)};
        cnt_nxt   = DIV_LEN_SHORT;
        op_nxt    = OP_CURVE;
        state_nxt = S_DIV;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_pwm_nxt    = pwm_r;
          out_status_nxt = status_r;
          out_rpm_nxt    = cur_r[RPM_W-1:RPM_FRAC];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and state registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmin_r       <= ADC_W'(30);
      tmax_r       <= ADC_W'(1000);
      maxrpm_r     <= 16'd400;
      ppr_r        <= 8'd1;
      bcut_r       <= ADC_W'(752);
      brec_r       <= ADC_W'(794);
      period_r     <= 16'd200;
      state_r      <= S_IDLE;
      op_r         <= OP_SAMPLE;
      last_pulse_r <= '0;
      interval_r   <= '0;
      last_speed_r <= '0;
      filt_r       <= '0;
      cur_r        <= '0;
      cut_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tmin_r       <= tmin_nxt;
      tmax_r       <= tmax_nxt;
      maxrpm_r     <= maxrpm_nxt;
      ppr_r        <= ppr_nxt;
      bcut_r       <= bcut_nxt;
      brec_r       <= brec_nxt;
      period_r     <= period_nxt;
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      last_pulse_r <= last_pulse_nxt;
      interval_r   <= interval_nxt;
      last_speed_r <= last_speed_nxt;
      filt_r       <= filt_nxt;
      cur_r        <= cur_nxt;
      cut_r        <= cut_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    thr_r        <= thr_nxt;
    brake_r      <= brake_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    den_r        <= den_nxt;
    cnt_r        <= cnt_nxt;
    d2_r         <= d2_nxt;
    pwm_r        <= pwm_nxt;
    status_r     <= status_nxt;
    out_pwm_r    <= out_pwm_nxt;
    out_status_r <= out_status_nxt;
    out_rpm_r    <= out_rpm_nxt;
  end

  // A tick makes the block busy on the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_TICK)) |=> !in_tready)
    else $error("control tick did not start the sequencer");

  // The divider never runs with an exhausted step count.
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("divider running with zero steps left");

  // Any cut status carries zero drive.
  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DRIVE)) |-> (out_pwm_r == '0))
    else $error("nonzero duty with a cut status");

  // The filter state only moves at the end of the filter step.
  a_filt_write: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(filt_r) |-> $past(state_r == S_RCP))
    else $error("filtered rpm changed outside the filter step");

  // A waiting result is never overwritten by a new one.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && state_r == S_DONE) |=> (state_r == S_DONE))
    else $error("result loaded over a waiting result");

endmodule
